### design/ffea_pkg.sv
// shared types and constants for the first-fit extent allocator
// no dependencies
`default_nettype none
package ffea_pkg;
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_OVERLAP  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_INSERT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHIFT_REQ,
    S_SHIFT_WR,
    S_WRITE,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

### design/first_fit_extent_allocator_unit.sv
// Free-extent allocator over a heap of byte offsets. Each request beat (action, size,
// address) gives one result beat (status, block_address, granted_bytes, free_bytes).
// The free extents sit in an address-sorted table with one registered read port; a
// request walks it entry by entry up to the first fit or the insertion point, then
// decides and writes, moves the entries one at a time on an insert or a removal, and
// presents the result. A size-zero request goes straight to the done state, which
// registers the result beat. The input stalls from the accepting beat until the result
// beat is taken. Reset loads a full heap into table entry 0; a cfg_wdata write (cfg_we),
// taken only while idle, reloads it.
// Depends on ffea_pkg and ffea_table.
`default_nettype none
module first_fit_extent_allocator_unit #(
  parameter int ADDR_BITS   = 24,
  parameter int MAX_EXTENTS = 64,
  parameter int ALIGN_BYTES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [ADDR_BITS:0]   cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [ADDR_BITS:0]   size,
  input  wire logic [ADDR_BITS-1:0] address,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [ADDR_BITS-1:0]      block_address,
  output logic [ADDR_BITS:0]        granted_bytes,
  output logic [ADDR_BITS:0]        free_bytes
);
  import ffea_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_EXTENTS);
  localparam int CNT_BITS = $clog2(MAX_EXTENTS + 1);
  localparam int AL_BITS  = $clog2(ALIGN_BYTES);
  localparam logic [ADDR_BITS:0] HEAP_MAX = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [ADDR_BITS+1:0] LOWX = (ADDR_BITS+2)'(ALIGN_BYTES - 1);
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_EXTENTS);

  state_t state, state_next;

  logic [ADDR_BITS:0]   heap, free_total;
  logic [CNT_BITS-1:0]  count;
  logic                 req_free;
  logic [ADDR_BITS:0]   bs;
  logic [ADDR_BITS-1:0] base;
  logic [CNT_BITS-1:0]  idx;
  logic [ADDR_BITS-1:0] prev_start, cur_start;
  logic [ADDR_BITS:0]   prev_len, cur_len;
  logic                 have_prev;
  // decided operation
  op_t                  op;
  logic [CNT_BITS-1:0]  op_idx, mv;
  logic [ADDR_BITS-1:0] op_start;
  logic [ADDR_BITS:0]   op_len;

  logic                 t_we;
  logic [IDX_BITS-1:0]  t_waddr, t_raddr;
  logic [ADDR_BITS-1:0] t_wstart, rd_start;
  logic [ADDR_BITS:0]   t_wlen, rd_len;

  ffea_table #(.ADDR_BITS(ADDR_BITS), .MAX_EXTENTS(MAX_EXTENTS), .IDX_BITS(IDX_BITS)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wstart(t_wstart), .wlen(t_wlen),
    .raddr(t_raddr), .rstart(rd_start), .rlen(rd_len)
  );

  logic [ADDR_BITS:0] cfg_len;
  logic [ADDR_BITS+1:0] bs_a, bs_f;
  always_comb begin
    cfg_len = (cfg_wdata > HEAP_MAX) ? HEAP_MAX : cfg_wdata;
    cfg_len[AL_BITS-1:0] = '0;
    bs_a = ({1'b0, size} + LOWX);
    bs_a[AL_BITS-1:0] = '0;
    bs_f = ({1'b0, size} + (ADDR_BITS+2)'(address[AL_BITS-1:0]) + LOWX);
    bs_f[AL_BITS-1:0] = '0;
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE) || out_valid;

  // scan compare on the entry just read
  logic scan_more;
  logic [ADDR_BITS:0] end_f, prev_end;
  always_comb begin
    end_f    = {1'b0, base} + bs;
    prev_end = {1'b0, prev_start} + prev_len;
    if (!req_free) scan_more = rd_len < bs;
    else           scan_more = rd_start < base;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_acc) state_next = (size == '0) ? S_DONE : S_SCAN_REQ;
      S_SCAN_REQ:  state_next = (idx < count) ? S_SCAN_CHK : S_DECIDE;
      S_SCAN_CHK:  state_next = scan_more ? S_SCAN_REQ : S_DECIDE;
      S_DECIDE:    state_next = S_WRITE;
      S_WRITE:     state_next = (op == OP_REMOVE || op == OP_INSERT) && mv != '0 ?
                                S_SHIFT_REQ : S_DONE;
      S_SHIFT_REQ: state_next = S_SHIFT_WR;
      S_SHIFT_WR:  state_next = (mv == CNT_BITS'(1)) ? S_DONE : S_SHIFT_REQ;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // read address and write port
  always_comb begin
    t_raddr  = idx[IDX_BITS-1:0];
    t_we     = 1'b0;
    t_waddr  = op_idx[IDX_BITS-1:0];
    t_wstart = op_start;
    t_wlen   = op_len;
    if (rst) begin
      t_we = 1'b1; t_waddr = '0; t_wstart = '0; t_wlen = HEAP_MAX;
    end else if (state == S_IDLE && cfg_we) begin
      t_we = 1'b1; t_waddr = '0; t_wstart = '0; t_wlen = cfg_len;
    end else if (state == S_WRITE && (op == OP_UPDATE || (op == OP_REMOVE && req_free))) begin
      t_we = 1'b1;
      // a double join rewrites the previous entry before the removal shift
      if (op == OP_REMOVE) t_waddr = IDX_BITS'(op_idx - 1'b1);
    end else if (state == S_SHIFT_REQ) begin
      // remove reads k+1 into k; insert reads k-1 into k
      t_raddr = (op == OP_REMOVE) ? IDX_BITS'(op_idx + 1'b1) : IDX_BITS'(op_idx - 1'b1);
    end else if (state == S_SHIFT_WR) begin
      t_we = 1'b1; t_wstart = rd_start; t_wlen = rd_len;
    end else if (state == S_DONE && op == OP_INSERT) begin
      t_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; heap <= HEAP_MAX; free_total <= HEAP_MAX;
      count <= CNT_BITS'(1); out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_acc) out_valid <= 1'b0;
      if (state == S_IDLE && cfg_we) begin
        heap <= cfg_len; free_total <= cfg_len;
        count <= (cfg_len == '0) ? '0 : CNT_BITS'(1);
      end
      unique case (state)
        S_IDLE: if (in_acc) begin
          req_free <= action; idx <= '0; have_prev <= 1'b0; op <= OP_NONE;
          base <= {address[ADDR_BITS-1:AL_BITS], {AL_BITS{1'b0}}};
          bs <= (action ? bs_f[ADDR_BITS+1] : bs_a[ADDR_BITS+1]) ? '1 :
                (action ? bs_f[ADDR_BITS:0] : bs_a[ADDR_BITS:0]);
          status <= ST_OK; block_address <= '0; granted_bytes <= '0;
        end
        S_SCAN_CHK: begin
          cur_start <= rd_start; cur_len <= rd_len;
          if (scan_more) begin
            prev_start <= rd_start; prev_len <= rd_len; have_prev <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_SCAN_REQ: begin
          cur_start <= rd_start; cur_len <= rd_len;
        end
        S_DECIDE: begin
          if (!req_free) begin
            if (bs > free_total || idx >= count) status <= ST_NO_SPACE;
            else begin
              block_address <= cur_start; granted_bytes <= bs;
              free_total <= free_total - bs;
              op_idx <= idx;
              if (cur_len == bs) begin
                op <= OP_REMOVE; mv <= count - idx - 1'b1; count <= count - 1'b1;
              end else begin
                op <= OP_UPDATE; op_start <= cur_start + bs[ADDR_BITS-1:0];
                op_len <= cur_len - bs;
              end
            end
          end else begin
            if (({1'b0, base} + {1'b0, bs} > {1'b0, heap}) ||
                (idx < count && end_f > {1'b0, cur_start}) ||
                (have_prev && prev_end > {1'b0, base})) status <= ST_OVERLAP;
            else begin
              if (have_prev && prev_end == {1'b0, base} &&
                  idx < count && end_f == {1'b0, cur_start}) begin
                op <= OP_REMOVE; op_idx <= idx;
                mv <= count - idx - 1'b1; count <= count - 1'b1;
                op_start <= prev_start; op_len <= prev_len + bs + cur_len;
                free_total <= free_total + bs; granted_bytes <= bs;
              end else if (have_prev && prev_end == {1'b0, base}) begin
                op <= OP_UPDATE; op_idx <= idx - 1'b1;
                op_start <= prev_start; op_len <= prev_len + bs;
                free_total <= free_total + bs; granted_bytes <= bs;
              end else if (idx < count && end_f == {1'b0, cur_start}) begin
                op <= OP_UPDATE; op_idx <= idx; op_start <= base; op_len <= cur_len + bs;
                free_total <= free_total + bs; granted_bytes <= bs;
              end else if (count >= CNT_MAX) status <= ST_FULL;
              else begin
                op <= OP_INSERT; op_idx <= count; mv <= count - idx;
                op_start <= base; op_len <= bs; count <= count + 1'b1;
                free_total <= free_total + bs; granted_bytes <= bs;
              end
            end
          end
        end
        S_SHIFT_WR: begin
          mv <= mv - 1'b1;
          op_idx <= (op == OP_REMOVE) ? op_idx + 1'b1 : op_idx - 1'b1;
        end
        S_DONE: begin
          out_valid <= 1'b1; free_bytes <= free_total;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/ffea_table.sv
// extent table memory: start and length per entry, one write port, one registered read port
// depends on ffea_pkg
`default_nettype none
module ffea_table #(
  parameter int ADDR_BITS   = 24,
  parameter int MAX_EXTENTS = 64,
  parameter int IDX_BITS    = 6
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IDX_BITS-1:0]  waddr,
  input  wire logic [ADDR_BITS-1:0] wstart,
  input  wire logic [ADDR_BITS:0]   wlen,
  input  wire logic [IDX_BITS-1:0]  raddr,
  output logic      [ADDR_BITS-1:0] rstart,
  output logic      [ADDR_BITS:0]   rlen
);
  import ffea_pkg::*;

  logic [ADDR_BITS-1:0] mem_start [MAX_EXTENTS];
  logic [ADDR_BITS:0]   mem_len   [MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr]   <= wlen;
    end
    rstart <= mem_start[raddr];
    rlen   <= mem_len[raddr];
  end
endmodule
`default_nettype wire

### bench/ffea_result_checker.sv
// result checker for first_fit_extent_allocator_unit: tracks the free-extent
// table from the request and config beats and compares every result beat.
// Depends on ffea_pkg.
module ffea_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [24:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        action,
  input  wire logic [24:0] size,
  input  wire logic [23:0] address,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  status,
  input  wire logic [23:0] block_address,
  input  wire logic [24:0] granted_bytes,
  input  wire logic [24:0] free_bytes,
  output int               mismatches,
  output int               outstanding
);
  import ffea_pkg::*;

  localparam int EXTENTS = 64;
  localparam longint unsigned HEAP_TOP = 64'd1 << 24;

  typedef struct {
    status_t     st;
    logic [23:0] blk;
    logic [24:0] granted;
    logic [24:0] free_after;
  } grant_t;

  longint unsigned ext_base [EXTENTS];
  longint unsigned ext_len [EXTENTS];
  int              ext_count;
  longint unsigned free_total;
  longint unsigned heap_len;
  grant_t          expected_grants[$];

  assign outstanding = expected_grants.size();

  function automatic void load_heap(longint unsigned raw);
    longint unsigned v;
    v = raw & 64'h1ff_ffff;
    if (v > HEAP_TOP) v = HEAP_TOP;
    v = v & ~64'hf;
    heap_len = v;
    ext_base[0] = 0;
    ext_len[0] = v;
    ext_count = (v != 0) ? 1 : 0;
    free_total = v;
  endfunction

  function automatic grant_t predict_grant(action_t act, longint unsigned sz,
                                           longint unsigned addr);
    grant_t r;
    longint unsigned bs, base, stop, prev_end;
    int i;
    bit has_next, join_prev, join_next;
    r.st = ST_OK;
    r.blk = '0;
    r.granted = '0;
    if (sz != 0 && act == ACT_ALLOC) begin
      bs = (sz + 15) & ~64'hf;
      i = 0;
      while (i < ext_count && ext_len[i] < bs) i++;
      if (bs > free_total || i >= ext_count) begin
        r.st = ST_NO_SPACE;
      end else begin
        r.blk = ext_base[i][23:0];
        if (ext_len[i] == bs) begin
          for (int k = i; k + 1 < ext_count; k++) begin
            ext_base[k] = ext_base[k+1];
            ext_len[k] = ext_len[k+1];
          end
          ext_count--;
        end else begin
          ext_base[i] += bs;
          ext_len[i] -= bs;
        end
        free_total -= bs;
        r.granted = bs[24:0];
      end
    end else if (sz != 0) begin
      base = addr & ~64'hf;
      bs = (sz + (addr & 64'hf) + 15) & ~64'hf;
      stop = base + bs;
      prev_end = 0;
      i = 0;
      while (i < ext_count && ext_base[i] < base) i++;
      has_next = i < ext_count;
      if (i > 0) prev_end = ext_base[i-1] + ext_len[i-1];
      if (stop > heap_len || (has_next && stop > ext_base[i]) ||
          (i > 0 && prev_end > base)) begin
        r.st = ST_OVERLAP;
      end else begin
        join_prev = i > 0 && prev_end == base;
        join_next = has_next && stop == ext_base[i];
        if (join_prev && join_next) begin
          ext_len[i-1] += bs + ext_len[i];
          for (int k = i; k + 1 < ext_count; k++) begin
            ext_base[k] = ext_base[k+1];
            ext_len[k] = ext_len[k+1];
          end
          ext_count--;
        end else if (join_prev) begin
          ext_len[i-1] += bs;
        end else if (join_next) begin
          ext_base[i] = base;
          ext_len[i] += bs;
        end else if (ext_count >= EXTENTS) begin
          r.st = ST_FULL;
        end else begin
          for (int k = ext_count; k > i; k--) begin
            ext_base[k] = ext_base[k-1];
            ext_len[k] = ext_len[k-1];
          end
          ext_base[i] = base;
          ext_len[i] = bs;
          ext_count++;
        end
        if (r.st == ST_OK) begin
          free_total += bs;
          r.granted = bs[24:0];
        end
      end
    end
    r.free_after = free_total[24:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      mismatches = 0;
      load_heap(HEAP_TOP);
      expected_grants.delete();
    end else begin
      if (cfg_we) load_heap(cfg_wdata);
      if (in_valid && !in_stall)
        expected_grants.push_back(predict_grant(action_t'(action), size, address));
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("result beat with no request waiting");
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (status !== want.st) begin
            $error("status expected %0d got %0d", want.st, status);
            mismatches++;
          end
          if (block_address !== want.blk) begin
            $error("block_address expected %0h got %0h", want.blk, block_address);
            mismatches++;
          end
          if (granted_bytes !== want.granted) begin
            $error("granted_bytes expected %0h got %0h", want.granted, granted_bytes);
            mismatches++;
          end
          if (free_bytes !== want.free_after) begin
            $error("free_bytes expected %0h got %0h", want.free_after, free_bytes);
            mismatches++;
          end
        end
      end
    end
  end
endmodule

### bench/first_fit_extent_allocator_unit_tb.sv
// testbench top for first_fit_extent_allocator_unit: directed and random
// allocate/free traffic over several heap sizes, with bursty requests and stalls.
// Depends on ffea_pkg, ffea_result_checker and the block itself.
module first_fit_extent_allocator_unit_tb;
  import ffea_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [24:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [24:0] size = '0;
  logic [23:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [23:0] block_address;
  logic [24:0] granted_bytes;
  logic [24:0] free_bytes;
  int          mismatches;
  int          outstanding;

  typedef struct {
    logic [23:0] at;
    logic [24:0] len;
  } block_t;

  block_t  live_blocks[$];
  action_t sent_actions[$];
  int      burst_left = 0;
  int      stall_mode = 0;
  int      stall_phase = 0;

  always #10 clk = ~clk;

  first_fit_extent_allocator_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .size(size),
    .address(address), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .block_address(block_address),
    .granted_bytes(granted_bytes), .free_bytes(free_bytes)
  );

  ffea_result_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .size(size),
    .address(address), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .block_address(block_address),
    .granted_bytes(granted_bytes), .free_bytes(free_bytes),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // receiver stall pattern, picks one of four stall characters from stall_phase
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= (stall_phase % 16) < 11;
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // remember granted blocks so frees can return them
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sent_actions.push_back(action_t'(action));
    if (!rst && out_valid && !out_stall && sent_actions.size() != 0) begin
      if (sent_actions.pop_front() == ACT_ALLOC && status == ST_OK && granted_bytes != 0)
        live_blocks.push_back('{block_address, granted_bytes});
    end
  end

  task automatic send(action_t act, logic [24:0] sz, logic [23:0] addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    size <= sz;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_heap(logic [24:0] v);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_blocks.delete();
  endtask

  task automatic random_traffic(int count, int span);
    int pick, idx;
    block_t b;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 19) == 0) send(ACT_ALLOC, 25'($urandom), 24'($urandom));
        else if ($urandom_range(0, 29) == 0) send(ACT_ALLOC, '0, 24'($urandom));
        else send(ACT_ALLOC, 25'($urandom_range(1, span)), 24'($urandom));
      end else if (pick < 85 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[idx];
        live_blocks.delete(idx);
        if ($urandom_range(0, 3) == 0)
          send(ACT_FREE, 25'(b.len - $urandom_range(0, 15) - (b.at[3:0] + 0)),
               24'(b.at + $urandom_range(0, 15)));
        else send(ACT_FREE, b.len, b.at);
      end else if (pick < 95) begin
        send(ACT_FREE, 25'($urandom_range(1, span)), 24'($urandom_range(0, span * 8)));
      end else begin
        send(ACT_FREE, 25'($urandom), 24'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and corner cases on the reset heap
    send(ACT_ALLOC, 0, 24'hff_ffff);
    send(ACT_FREE, 0, 24'hff_ffff);
    send(ACT_ALLOC, 25'h1ff_ffff, 0);
    send(ACT_ALLOC, 25'h100_0001, 0);
    send(ACT_ALLOC, 25'h100_0000, 0);
    send(ACT_ALLOC, 1, 0);
    send(ACT_FREE, 25'h100_0000, 0);
    send(ACT_FREE, 25'h1ff_ffff, 24'hff_ffff);
    send(ACT_ALLOC, 1, 0);
    send(ACT_ALLOC, 17, 0);
    send(ACT_ALLOC, 16, 0);
    send(ACT_FREE, 1, 0);
    send(ACT_FREE, 16, 24'h10);
    send(ACT_FREE, 8, 24'h1f);
    send(ACT_FREE, 16, 24'h20);
    send(ACT_FREE, 1, 24'hff_ffff);
    send(ACT_ALLOC, 25'h0ff_fff0, 0);
    send(ACT_FREE, 25'h100_0000, 0);
    send(ACT_FREE, 16, 24'h100);

    set_heap(25'd4096);
    random_traffic(150, 128);

    // fill with 16-byte blocks, then punch holes until the table is full
    set_heap(25'd4096);
    for (int k = 0; k < 257; k++) send(ACT_ALLOC, 16, 0);
    for (int k = 0; k < 66; k++) send(ACT_FREE, 16, 24'(32 * k + 16));
    random_traffic(60, 32);

    set_heap(25'd1000);
    random_traffic(120, 64);
    set_heap(25'h1ff_ffff);
    random_traffic(120, 25'h10_0000);
    set_heap(25'd0);
    random_traffic(30, 64);
    set_heap(25'd65536);
    random_traffic(150, 2048);
    set_heap(25'h100_0000);
    random_traffic(60, 4096);

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("first_fit_extent_allocator_unit regression: pass");
    else $display("first_fit_extent_allocator_unit regression: fail");
    $finish;
  end

  initial begin
    #400000000;
    $display("first_fit_extent_allocator_unit regression: fail");
    $finish;
  end
endmodule
